FILE: hw/rtl/fpdgs_pkg.sv
// Shared constants, rule tables and helper functions of the fuzzy PD gain scheduler.
package fpdgs_pkg;

	localparam int NUM_LEVELS_DEF = 7;
	localparam int RULE_DIM       = 7;

	localparam int MAG_W   = 15;
	localparam int DIST_W  = 11;
	localparam int W_W     = 17;
	localparam int RECIP_W = 24;
	localparam int CFG_W   = 11;
	localparam int GAIN_W  = 20;

	localparam logic [W_W-1:0] WONE = 17'h10000;

	// error breakpoints: 0, then 1500 with 1300 spacing; change: 500 spacing
	localparam int E_BP1   = 1500;
	localparam int E_STEP  = 1300;
	localparam int C_STEP  = 500;

	localparam logic [DIST_W-1:0] E_WIDTH0 = DIST_W'(E_BP1);
	localparam logic [DIST_W-1:0] E_WIDTH  = DIST_W'(E_STEP);
	localparam logic [DIST_W-1:0] C_WIDTH  = DIST_W'(C_STEP);

	// floor(2^32 / width)
	localparam logic [RECIP_W-1:0] E_RECIP0 = RECIP_W'((64'd1 << 32) / E_BP1);
	localparam logic [RECIP_W-1:0] E_RECIP  = RECIP_W'((64'd1 << 32) / E_STEP);
	localparam logic [RECIP_W-1:0] C_RECIP  = RECIP_W'((64'd1 << 32) / C_STEP);

	typedef enum logic [1:0] {
		REG_KP_BASE = 2'd0,
		REG_KP_STEP = 2'd1,
		REG_KD_BASE = 2'd2,
		REG_KD_STEP = 2'd3
	} cfg_reg_t;

	localparam logic [2:0] KP_RULES [RULE_DIM][RULE_DIM] = '{
		'{3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd0, 3'd0},
		'{3'd3, 3'd3, 3'd2, 3'd1, 3'd1, 3'd1, 3'd0},
		'{3'd4, 3'd3, 3'd3, 3'd2, 3'd2, 3'd1, 3'd1},
		'{3'd4, 3'd4, 3'd3, 3'd3, 3'd2, 3'd1, 3'd1},
		'{3'd4, 3'd4, 3'd4, 3'd3, 3'd2, 3'd2, 3'd1},
		'{3'd5, 3'd5, 3'd5, 3'd4, 3'd4, 3'd3, 3'd2},
		'{3'd6, 3'd6, 3'd5, 3'd5, 3'd4, 3'd3, 3'd3}
	};

	localparam logic [2:0] KD_RULES [RULE_DIM][RULE_DIM] = '{
		'{3'd3, 3'd3, 3'd4, 3'd5, 3'd5, 3'd6, 3'd6},
		'{3'd3, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5},
		'{3'd2, 3'd3, 3'd3, 3'd4, 3'd5, 3'd5, 3'd5},
		'{3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd5},
		'{3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3},
		'{3'd0, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3},
		'{3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2}
	};

	function automatic logic [MAG_W-1:0] e_bp(input int k);
		return (k == 0) ? '0 : MAG_W'(E_STEP * k + (E_BP1 - E_STEP));
	endfunction

	function automatic logic [MAG_W-1:0] c_bp(input int k);
		return MAG_W'(C_STEP * k);
	endfunction

	// |x| with the most negative value saturated
	function automatic logic [MAG_W-1:0] mag(input logic [15:0] x);
		logic [15:0] neg;
		neg = 16'(~x + 16'd1);
		if (!x[15])
			return x[MAG_W-1:0];
		else if (neg[15])
			return '1;
		else
			return neg[MAG_W-1:0];
	endfunction

	function automatic logic [2:0] kp_level(input logic [4:0] r, input logic [4:0] c);
		if (r < 5'(RULE_DIM) && c < 5'(RULE_DIM))
			return KP_RULES[r[2:0]][c[2:0]];
		else
			return 3'd0;
	endfunction

	function automatic logic [2:0] kd_level(input logic [4:0] r, input logic [4:0] c);
		if (r < 5'(RULE_DIM) && c < 5'(RULE_DIM))
			return KD_RULES[r[2:0]][c[2:0]];
		else
			return 3'd0;
	endfunction

endpackage

FILE: hw/rtl/fuzzy_pd_gain_scheduler.sv
// Fuzzy PD gain scheduler: eight-stage pipeline from error sample to kp/kd gains.
//
// Takes one request per clock and returns kp and kd gains (signed, 8 fraction
// bits) from the eight-stage pipeline below; throughput is one item per cycle
// while the output is not stalled. Each stage holds its request until the next
// stage can take it, so bubbles close up and a stalled output still lets the
// front of the pipe fill. Stages:
//   s1 magnitudes and breakpoint compares
//   s2 segment index, distance to upper breakpoint
//   s3 reciprocal multiply (estimate of distance*65536/width)
//   s4 remainder check and +1 correction -> weights in Q1.16
//   s5 weight products and singletons base+step*level from the rule tables
//   s6 product * singleton, eight signed multipliers
//   s7 pairwise sums
//   s8 final sum and round to nearest, ties up, to 8 fraction bits
// Terms outside NUM_LEVELS get a zero singleton, which drops them. The user
// writes config registers only while the pipe is empty; unchecked by the RTL.
module fuzzy_pd_gain_scheduler #(
	parameter int NUM_LEVELS = fpdgs_pkg::NUM_LEVELS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [31:0]                        s_axis_tdata,  // error_value, error_change
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [39:0]                        m_axis_tdata,  // kp_gain, kd_gain
	input  logic                               cfg_we,
	input  fpdgs_pkg::cfg_reg_t                cfg_index,
	input  logic [fpdgs_pkg::CFG_W-1:0]        cfg_wdata
);
	import fpdgs_pkg::*;

	localparam int SEG_W = $clog2(NUM_LEVELS);
	localparam int NS    = 8;

	// config
	logic [10:0] kp_base_q, kd_base_q;
	logic [7:0]  kp_step_q, kd_step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_base_q <= 11'd145;
			kp_step_q <= 8'd20;
			kd_base_q <= 11'd14;
			kd_step_q <= 8'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KP_BASE: kp_base_q <= cfg_wdata;
				REG_KP_STEP: kp_step_q <= cfg_wdata[7:0];
				REG_KD_BASE: kd_base_q <= cfg_wdata;
				REG_KD_STEP: kd_step_q <= cfg_wdata[7:0];
			endcase
		end
	end

	// handshake: a stage loads when empty or when the next one loads
	logic [NS:1]   vld;
	logic [NS+1:1] rdy;

	always_comb begin
		rdy[NS+1] = m_axis_tready;
		for (int k = NS; k >= 1; k--)
			rdy[k] = !vld[k] || rdy[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (rdy[1]) vld[1] <= s_axis_tvalid;
			for (int k = 2; k <= NS; k++)
				if (rdy[k]) vld[k] <= vld[k-1];
		end
	end

	assign s_axis_tready = rdy[1];
	assign m_axis_tvalid = vld[NS];

	// s1: magnitudes and compares
	logic [MAG_W-1:0]      em_s1, cm_s1;
	logic [NUM_LEVELS-1:1] ef_s1, cf_s1;
	logic [MAG_W-1:0]      em_c, cm_c;
	logic [NUM_LEVELS-1:1] ef_c, cf_c;

	always_comb begin
		em_c = mag(s_axis_tdata[15:0]);
		cm_c = mag(s_axis_tdata[31:16]);
		for (int k = 1; k < NUM_LEVELS; k++) begin
			ef_c[k] = em_c >= e_bp(k);
			cf_c[k] = cm_c >= c_bp(k);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			em_s1 <= em_c;
			cm_s1 <= cm_c;
			ef_s1 <= ef_c;
			cf_s1 <= cf_c;
		end
	end

	// s2: segment and distance
	logic [SEG_W-1:0]  eseg_s2, cseg_s2, eseg_c, cseg_c;
	logic [DIST_W-1:0] edist_s2, cdist_s2;
	logic              etop_s2, ctop_s2, ewide_s2;
	logic [MAG_W-1:0]  enbp_c, cnbp_c;

	always_comb begin
		eseg_c = '0;
		cseg_c = '0;
		for (int k = 1; k < NUM_LEVELS; k++) begin
			eseg_c = eseg_c + SEG_W'(ef_s1[k]);
			cseg_c = cseg_c + SEG_W'(cf_s1[k]);
		end
		enbp_c = '0;
		cnbp_c = '0;
		for (int k = 0; k < NUM_LEVELS - 1; k++) begin
			if (eseg_c == SEG_W'(k)) enbp_c = e_bp(k + 1);
			if (cseg_c == SEG_W'(k)) cnbp_c = c_bp(k + 1);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			eseg_s2  <= eseg_c;
			cseg_s2  <= cseg_c;
			edist_s2 <= DIST_W'(enbp_c - em_s1);
			cdist_s2 <= DIST_W'(cnbp_c - cm_s1);
			etop_s2  <= eseg_c == SEG_W'(NUM_LEVELS - 1);
			ctop_s2  <= cseg_c == SEG_W'(NUM_LEVELS - 1);
			ewide_s2 <= eseg_c == '0;
		end
	end

	// s3: quotient estimate, at most one below the rounded quotient
	logic [SEG_W-1:0]  eseg_s3, cseg_s3;
	logic [DIST_W-1:0] edist_s3, cdist_s3;
	logic              etop_s3, ctop_s3, ewide_s3;
	logic [W_W-1:0]    eq_s3, cq_s3;
	logic [34:0]       eqm_c, cqm_c;

	always_comb begin
		eqm_c = 35'(edist_s2) * 35'(ewide_s2 ? E_RECIP0 : E_RECIP);
		cqm_c = 35'(cdist_s2) * 35'(C_RECIP);
	end

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			eseg_s3  <= eseg_s2;
			cseg_s3  <= cseg_s2;
			edist_s3 <= edist_s2;
			cdist_s3 <= cdist_s2;
			etop_s3  <= etop_s2;
			ctop_s3  <= ctop_s2;
			ewide_s3 <= ewide_s2;
			eq_s3    <= eqm_c[32:16];
			cq_s3    <= cqm_c[32:16];
		end
	end

	// s4: remainder check, weights
	logic [SEG_W-1:0]  eseg_s4, cseg_s4;
	logic [W_W-1:0]    ew0_s4, cw0_s4;
	logic [DIST_W-1:0] e_d;
	logic [27:0]       e_num, c_num, e_rem, c_rem;

	always_comb begin
		e_d   = ewide_s3 ? E_WIDTH0 : E_WIDTH;
		e_num = (28'(edist_s3) << 16) + 28'(e_d[DIST_W-1:1]);
		c_num = (28'(cdist_s3) << 16) + 28'(C_WIDTH[DIST_W-1:1]);
		e_rem = e_num - 28'(eq_s3) * 28'(e_d);
		c_rem = c_num - 28'(cq_s3) * 28'(C_WIDTH);
	end

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			eseg_s4 <= eseg_s3;
			cseg_s4 <= cseg_s3;
			ew0_s4  <= etop_s3 ? WONE : eq_s3 + W_W'(e_rem >= 28'(e_d));
			cw0_s4  <= ctop_s3 ? WONE : cq_s3 + W_W'(c_rem >= 28'(C_WIDTH));
		end
	end

	// s5: weight products and singletons; index i = 2*dc + de
	logic [32:0]        p_s5 [4];
	logic signed [12:0] skp_s5 [4], skd_s5 [4];
	logic [W_W-1:0]     ew_c [2], cw_c [2];
	logic [32:0]        p_c [4];
	logic signed [12:0] skp_c [4], skd_c [4];
	logic [4:0]         r_c, col_c;
	logic               in_c;
	logic [2:0]         lkp_c, lkd_c;

	always_comb begin
		ew_c[0] = ew0_s4;
		ew_c[1] = WONE - ew0_s4;
		cw_c[0] = cw0_s4;
		cw_c[1] = WONE - cw0_s4;
		for (int i = 0; i < 4; i++) begin
			r_c   = 5'(cseg_s4) + 5'(i / 2);
			col_c = 5'(eseg_s4) + 5'(i % 2);
			in_c  = r_c < 5'(NUM_LEVELS) && col_c < 5'(NUM_LEVELS);
			lkp_c = kp_level(r_c, col_c);
			lkd_c = kd_level(r_c, col_c);
			p_c[i] = 33'(cw_c[i/2]) * 33'(ew_c[i%2]);
			skp_c[i] = in_c ? $signed({{2{kp_base_q[10]}}, kp_base_q})
				+ $signed(kp_step_q) * $signed({1'b0, lkp_c}) : 13'sd0;
			skd_c[i] = in_c ? $signed({{2{kd_base_q[10]}}, kd_base_q})
				+ $signed(kd_step_q) * $signed({1'b0, lkd_c}) : 13'sd0;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[5]) begin
			p_s5   <= p_c;
			skp_s5 <= skp_c;
			skd_s5 <= skd_c;
		end
	end

	// s6: terms
	logic signed [46:0] tkp_s6 [4], tkd_s6 [4];

	always_ff @(posedge clk) begin
		if (rdy[6]) begin
			for (int i = 0; i < 4; i++) begin
				tkp_s6[i] <= $signed({1'b0, p_s5[i]}) * skp_s5[i];
				tkd_s6[i] <= $signed({1'b0, p_s5[i]}) * skd_s5[i];
			end
		end
	end

	// s7: pair sums
	logic signed [47:0] pkp_s7 [2], pkd_s7 [2];

	always_ff @(posedge clk) begin
		if (rdy[7]) begin
			for (int j = 0; j < 2; j++) begin
				pkp_s7[j] <= $signed({tkp_s6[2*j][46], tkp_s6[2*j]})
					+ $signed({tkp_s6[2*j+1][46], tkp_s6[2*j+1]});
				pkd_s7[j] <= $signed({tkd_s6[2*j][46], tkd_s6[2*j]})
					+ $signed({tkd_s6[2*j+1][46], tkd_s6[2*j+1]});
			end
		end
	end

	// s8: total, round half up at bit 24
	logic [GAIN_W-1:0] kp_s8, kd_s8;
	logic [48:0]       akp_c, akd_c;

	always_comb begin
		akp_c = {pkp_s7[0][47], pkp_s7[0]} + {pkp_s7[1][47], pkp_s7[1]} + (49'd1 << 23);
		akd_c = {pkd_s7[0][47], pkd_s7[0]} + {pkd_s7[1][47], pkd_s7[1]} + (49'd1 << 23);
	end

	always_ff @(posedge clk) begin
		if (rdy[8]) begin
			kp_s8 <= akp_c[43:24];
			kd_s8 <= akd_c[43:24];
		end
	end

	assign m_axis_tdata = {kd_s8, kp_s8};

	// checks
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> vld[1])
		else $error("input stalled with empty first stage");

	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld[4] |-> (ew0_s4 <= WONE) && (cw0_s4 <= WONE))
		else $error("membership weight above one");

	a_quotient_fix: assert property (@(posedge clk) disable iff (!arst_n)
		vld[3] && !etop_s3 && !ctop_s3 |->
			(e_rem < 28'(2) * 28'(e_d)) && (c_rem < 28'(2) * 28'(C_WIDTH)))
		else $error("reciprocal estimate off by more than one");

endmodule
